// ===== design/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search core.
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    localparam int STATION_W = 17;
    localparam int INDEX_W   = 11;
    localparam int COUNT_W   = 12;
    localparam int STEP_W    = 11;
    localparam int ROUND_W   = 3;

    localparam logic [ROUND_W-1:0] GIVE_UP_ROUNDS = 3'd3;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [INDEX_W-1:0]   entry_index;
        logic [STATION_W-1:0] station_number;
    } t_cmd;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] position;
    } t_result;

    typedef struct packed {
        logic wr;
        logic load;
        logic rd;
        logic hit;
        logic adv;
    } t_dp_ctrl;

    typedef struct packed {
        logic empty;
        logic hit;
        logic give_up;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/stbs_datapath.sv =====
// Datapath: station table memory, entry count register and probe arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module stbs_datapath #(
    parameter int TABLE_DEPTH = 2048
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [stbs_pkg::COUNT_W-1:0]        i_cfg_wdata,
    input  wire stbs_pkg::t_cmd                      i_cmd,
    input  wire stbs_pkg::t_dp_ctrl                  i_ctrl,
    output stbs_pkg::t_dp_stat                       o_stat,
    output stbs_pkg::t_result                        o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = stbs_pkg::COUNT_W;

    logic [stbs_pkg::STATION_W-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0]                   r_entry_count;
    logic [stbs_pkg::STATION_W-1:0]  r_key;
    logic [stbs_pkg::STATION_W-1:0]  r_rdata;
    logic [CW-1:0]                   r_n;
    logic [CW-1:0]                   r_idx;
    logic [stbs_pkg::STEP_W-1:0]     r_step;
    logic [stbs_pkg::ROUND_W-1:0]    r_rounds;
    logic                            r_single;
    logic                            r_found;
    logic [CW-1:0]                   r_pos;

    logic [CW-1:0]                   n_count;
    logic [CW-1:0]                   n_half;
    logic [CW-1:0]                   n_half_inc;
    logic signed [CW+1:0]            n_idx_s;
    logic [CW-1:0]                   n_idx;
    logic [CW-1:0]                   n_step_inc;
    logic [stbs_pkg::STEP_W-1:0]     n_step;
    logic [stbs_pkg::ROUND_W-1:0]    n_rounds;

    always_comb begin
        if (32'(r_entry_count) > TABLE_DEPTH) begin
            n_count = CW'(TABLE_DEPTH);
        end else begin
            n_count = r_entry_count;
        end
        n_half     = n_count >> 1;
        n_half_inc = n_half + CW'(1);
    end

    always_comb begin
        if (r_key > r_rdata) begin
            n_idx_s = $signed({2'b00, r_idx}) + $signed({3'b000, r_step});
        end else begin
            n_idx_s = $signed({2'b00, r_idx}) - $signed({3'b000, r_step});
        end
        n_step_inc = {1'b0, r_step} + CW'(1);
        n_step     = stbs_pkg::STEP_W'(n_step_inc >> 1);
        if (n_step == stbs_pkg::STEP_W'(1)) begin
            n_rounds = r_rounds + stbs_pkg::ROUND_W'(1);
        end else begin
            n_rounds = r_rounds;
        end
        if (n_idx_s > $signed({2'b00, r_n - CW'(1)})) begin
            n_idx = r_n - CW'(1);
        end else if (n_idx_s < 0) begin
            n_idx = '0;
        end else begin
            n_idx = CW'(n_idx_s);
        end
    end

    always_comb begin
        o_stat.empty   = (n_count == '0);
        o_stat.hit     = (r_key == r_rdata);
        o_stat.give_up = r_single || (r_rounds > stbs_pkg::GIVE_UP_ROUNDS);
        o_result.found    = r_found;
        o_result.position = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr && (32'(i_cmd.entry_index) < TABLE_DEPTH)) begin
            mem[AW'(i_cmd.entry_index)] <= i_cmd.station_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_rdata <= mem[AW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key    <= i_cmd.station_number;
            r_n      <= n_count;
            r_idx    <= n_half;
            r_step   <= stbs_pkg::STEP_W'(n_half_inc >> 1);
            r_rounds <= '0;
            r_single <= (n_count == CW'(1));
            r_found  <= 1'b0;
            r_pos    <= '0;
        end else if (i_ctrl.hit) begin
            r_found  <= 1'b1;
            r_pos    <= r_idx + CW'(1);
        end else if (i_ctrl.adv) begin
            r_idx    <= n_idx;
            r_step   <= n_step;
            r_rounds <= n_rounds;
        end
    end

endmodule

`default_nettype wire

// ===== design/stbs_controller.sv =====
// Controller: state machine that sequences table writes and search probes.
`timescale 1ns / 1ps
`default_nettype none

module stbs_controller (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic                 i_func,
    input  wire stbs_pkg::t_dp_stat   i_stat,
    output stbs_pkg::t_dp_ctrl        o_ctrl,
    output logic                      busy,
    output logic                      o_result_valid
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_func == stbs_pkg::FUNC_WRITE) begin
                        o_ctrl.wr = 1'b1;
                    end else begin
                        o_ctrl.load = 1'b1;
                        n_state = i_stat.empty ? ST_DONE : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                o_ctrl.rd = 1'b1;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.hit) begin
                    o_ctrl.hit = 1'b1;
                    n_state    = ST_DONE;
                end else if (i_stat.give_up) begin
                    n_state = ST_DONE;
                end else begin
                    o_ctrl.adv = 1'b1;
                    n_state    = ST_FETCH;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = (r_state == ST_DONE);

endmodule

`default_nettype wire

// ===== design/sorted_table_binary_search_core.sv =====
// Top level of the sorted station table with a fixed-schedule binary search.
//
// Channel   Direction  Handshake                   Payload
// command   in         start high, busy low        i_cmd (t_cmd)
// result    out        o_result_valid, one cycle   o_result (t_result)
// config    in         i_cfg_we                    i_cfg_wdata (entry count)
//
// A write transfer leaves the block idle and ready for the next.
// A search runs its probes one after another, each a registered memory read
// (FETCH) and then a compare (EVAL), and then presents the result in DONE.
// Without a match the probe count is about log2(n) + 2 and at least five
// for n above one; a full table of 2048 entries needs at most 13 probes.
// An empty table answers in the cycle after the transfer.
// Reset clears the controller and the entry count; table contents are kept.
// The result strobe lasts one cycle and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = 2048
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire stbs_pkg::t_cmd                  i_cmd,
    output logic                                 o_result_valid,
    output stbs_pkg::t_result                    o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [stbs_pkg::COUNT_W-1:0]    i_cfg_wdata
);

    stbs_pkg::t_dp_ctrl ctrl;
    stbs_pkg::t_dp_stat stat;

    stbs_controller u_controller (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_func         (i_cmd.func),
        .i_stat         (stat),
        .o_ctrl         (ctrl),
        .busy           (busy),
        .o_result_valid (o_result_valid)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
